// ----- rtl/sph_density_accumulator_top_defines.svh -----
`ifndef SPH_DENSITY_ACCUMULATOR_TOP_DEFINES_SVH
`define SPH_DENSITY_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define SDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sda_pkg.sv -----
`timescale 1ns / 1ps
package sda_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W = 24;
	localparam int MAG_W   = 24;
	localparam int RAD_W   = 23;
	localparam int SQ_W    = 48;
	localparam int HSQ_W   = 2 * RAD_W;
	localparam int COEFF_W = 32;
	localparam int SUM_W   = 32;
	localparam int ADDR_W  = 4;

	localparam logic [RAD_W-1:0]   RADIUS_RST   = 23'd65536;
	localparam logic [COEFF_W-1:0] DENSITY_RST  = 32'd156457;
	localparam logic [COEFF_W-1:0] NEAR_RST     = 32'd312914;

	// register indexes (word address bits)
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_DCOEFF = 2'd1;
	localparam logic [1:0] REG_NCOEFF = 2'd2;

	// classified neighbour between front and back
	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic            in_range;
		logic            last;
	} sda_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sda_qstat_t;
endpackage

// ----- rtl/sph_density_accumulator_top.sv -----
`timescale 1ns / 1ps
// SPH density accumulator.
// Input stream (s_*): one neighbour displacement per transaction, dx/dy/dz in
// s_tdata, s_tlast marking the final neighbour of a particle. Output stream
// (m_*): one transaction per particle carrying the saturated density and near
// density sums, emitted after the item flagged last has been accumulated.
// APB port: radius h at 0x0, density coefficient at 0x4, near coefficient at 0x8.
// Back end: a neighbour inside the radius goes through the digit-serial square
// root, the kernel products, the coefficient products on a shared 32x32
// multiplier and the accumulate; one outside goes straight to the accumulate.
// The front end (registered magnitudes and squares, then the radius test) feeds a
// two-entry queue, so input is still accepted while the back end is busy, until
// the queue and the front end are full.
// Reset clears the sums, the queue, the pipe and loads the default registers.
// When m_tready is low the result is held and the back end stops at the next
// last item; the queue then fills and s_tready drops.
module sph_density_accumulator_top #(
	parameter int FRAC_BITS = sda_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [71:0]                s_tdata,  // dx, dy, dz
	input  logic                       s_tlast,  // last_neighbor
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [63:0]                m_tdata,  // density, near_density
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sda_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import sda_pkg::*;

	logic [RAD_W-1:0]   radius_q;
	logic [COEFF_W-1:0] dcoeff_q, ncoeff_q;
	logic               wr_en;
	logic               push, pop;
	sda_item_t          push_item, head;
	sda_qstat_t         qstat;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			dcoeff_q <= DENSITY_RST;
			ncoeff_q <= NEAR_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
				REG_DCOEFF: dcoeff_q <= pwdata;
				REG_NCOEFF: ncoeff_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RADIUS: prdata = 32'(radius_q);
			REG_DCOEFF: prdata = dcoeff_q;
			REG_NCOEFF: prdata = ncoeff_q;
			default:    prdata = '0;
		endcase
	end

	sda_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.dx            (s_tdata[23:0]),
		.dy            (s_tdata[47:24]),
		.dz            (s_tdata[71:48]),
		.last_neighbor (s_tlast),
		.radius        (radius_q),
		.qstat         (qstat),
		.push          (push),
		.push_item     (push_item)
	);

	sda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	sda_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.qstat              (qstat),
		.pop                (pop),
		.radius             (radius_q),
		.density_coeff      (dcoeff_q),
		.near_density_coeff (ncoeff_q),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.density            (m_tdata[31:0]),
		.near_density       (m_tdata[63:32])
	);
endmodule

// ----- rtl/sda_front.sv -----
`timescale 1ns / 1ps
module sda_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sda_pkg::COORD_W-1:0] dx,
	input  logic [sda_pkg::COORD_W-1:0] dy,
	input  logic [sda_pkg::COORD_W-1:0] dz,
	input  logic                        last_neighbor,
	input  logic [sda_pkg::RAD_W-1:0]   radius,
	input  sda_pkg::sda_qstat_t         qstat,
	output logic                        push,
	output sda_pkg::sda_item_t          push_item
);
	import sda_pkg::*;

	logic             en;
	logic             valid_s1, valid_s2;
	logic [MAG_W-1:0] ax_s1, ay_s1, az_s1;
	logic             last_s1, last_s2;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [HSQ_W-1:0] hsq_s2;
	logic [SQ_W-1:0]  sq_sum;

	function automatic logic [MAG_W-1:0] mag(input logic [COORD_W-1:0] v);
		mag = v[COORD_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
	endfunction

	// whole pipe moves unless stage 2 holds an item and the queue is full
	assign en       = !(valid_s2 && qstat.full);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: magnitudes; stage 2: squares
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= mag(dx);
			ay_s1   <= mag(dy);
			az_s1   <= mag(dz);
			last_s1 <= last_neighbor;
			sqx_s2  <= ax_s1 * ax_s1;
			sqy_s2  <= ay_s1 * ay_s1;
			sqz_s2  <= az_s1 * az_s1;
			hsq_s2  <= radius * radius;
			last_s2 <= last_s1;
		end
	end

	// sum and radius test into the queue
	assign sq_sum             = sqx_s2 + sqy_s2 + sqz_s2;
	assign push               = valid_s2 && en;
	assign push_item.sq       = sq_sum;
	assign push_item.in_range = (sq_sum <= SQ_W'(hsq_s2));
	assign push_item.last     = last_s2;
endmodule

// ----- rtl/sda_queue.sv -----
`timescale 1ns / 1ps
module sda_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sda_pkg::sda_item_t  push_item,
	input  logic                pop,
	output sda_pkg::sda_item_t  head,
	output sda_pkg::sda_qstat_t qstat
);
	import sda_pkg::*;

	sda_item_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end
endmodule

// ----- rtl/sda_back.sv -----
`timescale 1ns / 1ps
`include "sph_density_accumulator_top_defines.svh"
module sda_back #(
	parameter int FRAC_BITS = sda_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sda_pkg::sda_item_t          head,
	input  sda_pkg::sda_qstat_t         qstat,
	output logic                        pop,
	input  logic [sda_pkg::RAD_W-1:0]   radius,
	input  logic [sda_pkg::COEFF_W-1:0] density_coeff,
	input  logic [sda_pkg::COEFF_W-1:0] near_density_coeff,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sda_pkg::SUM_W-1:0]   density,
	output logic [sda_pkg::SUM_W-1:0]   near_density
);
	import sda_pkg::*;

	localparam int V2W   = 2 * RAD_W - FRAC_BITS;
	localparam int V3W   = V2W + RAD_W - FRAC_BITS;
	localparam int PLO_W = 64 - FRAC_BITS;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQRT = 9'b000000010,
		ST_VV   = 9'b000000100,
		ST_V2V  = 9'b000001000,
		ST_K2LO = 9'b000010000,
		ST_K2HI = 9'b000100000,
		ST_K3LO = 9'b001000000,
		ST_K3HI = 9'b010000000,
		ST_ACC  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [SQ_W-1:0]    rem_q, res_q, bit_q;
	logic               last_q;
	logic [RAD_W-1:0]   v_q;
	logic [V2W-1:0]     v2_q;
	logic [V3W-1:0]     v3_q;
	logic [PLO_W-1:0]   plo_q;
	logic [SUM_W-1:0]   term2_q, term3_q;
	logic [SUM_W-1:0]   dsum_q, nsum_q;
	logic               out_valid_q;
	logic [SUM_W-1:0]   out_d_q, out_n_q;

	logic [SQ_W:0]            trial;
	logic [2*RAD_W-1:0]       prod_vv;
	logic [V2W+RAD_W-1:0]     prod_v2v;
	logic [63:0]              a_ext;
	logic [31:0]              mul_a, mul_b;
	logic [63:0]              mul_p;
	logic [PLO_W:0]           rsum;
	logic [SUM_W-1:0]         term;
	logic [SUM_W:0]           dsum_w, nsum_w;
	logic [SUM_W-1:0]         dsum_n, nsum_n;
	logic                     acc_block;

	// one square-root digit per cycle
	assign trial = (SQ_W+1)'(res_q) + (SQ_W+1)'(bit_q);

	assign prod_vv  = v_q * v_q;
	assign prod_v2v = v2_q * v_q;

	// shared 32x32 multiplier for the coefficient products
	always_comb begin
		a_ext = (state_q == ST_K2LO || state_q == ST_K2HI) ? 64'(v2_q) : 64'(v3_q);
		mul_b = (state_q == ST_K2LO || state_q == ST_K2HI) ? density_coeff
			: near_density_coeff;
		mul_a = (state_q == ST_K2LO || state_q == ST_K3LO) ? a_ext[31:0] : a_ext[63:32];
	end
	assign mul_p = mul_a * mul_b;

	// high partial product merged with the low one, saturating
	assign rsum = (PLO_W+1)'({mul_p[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}})
		+ (PLO_W+1)'(plo_q);
	assign term = ((|mul_p[63:FRAC_BITS]) || (|rsum[PLO_W:32])) ? '1 : rsum[31:0];

	// saturating accumulate
	assign dsum_w = (SUM_W+1)'(dsum_q) + (SUM_W+1)'(term2_q);
	assign nsum_w = (SUM_W+1)'(nsum_q) + (SUM_W+1)'(term3_q);
	assign dsum_n = dsum_w[SUM_W] ? '1 : dsum_w[SUM_W-1:0];
	assign nsum_n = nsum_w[SUM_W] ? '1 : nsum_w[SUM_W-1:0];

	assign acc_block = last_q && out_valid_q && !out_ready;
	assign pop       = (state_q == ST_IDLE) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dsum_q      <= '0;
			nsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// new result wins over the transaction that empties the register
			if (state_q == ST_ACC && last_q && !acc_block) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) state_q <= head.in_range ? ST_SQRT : ST_ACC;
				end
				ST_SQRT: begin
					if (bit_q[0]) state_q <= ST_VV;
				end
				ST_VV:   state_q <= ST_V2V;
				ST_V2V:  state_q <= ST_K2LO;
				ST_K2LO: state_q <= ST_K2HI;
				ST_K2HI: state_q <= ST_K3LO;
				ST_K3LO: state_q <= ST_K3HI;
				ST_K3HI: state_q <= ST_ACC;
				ST_ACC: begin
					if (!acc_block) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							dsum_q      <= '0;
							nsum_q      <= '0;
						end else begin
							dsum_q <= dsum_n;
							nsum_q <= nsum_n;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q   <= head.sq;
				res_q   <= '0;
				bit_q   <= SQ_W'(1) << (SQ_W - 2);
				last_q  <= head.last;
				term2_q <= '0;
				term3_q <= '0;
			end
			ST_SQRT: begin
				if ((SQ_W+1)'(rem_q) >= trial) begin
					rem_q <= rem_q - trial[SQ_W-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				v_q   <= radius;
			end
			ST_VV: begin
				v_q  <= v_q - res_q[RAD_W-1:0];
			end
			ST_V2V: begin
				v2_q <= prod_vv[2*RAD_W-1:FRAC_BITS];
			end
			ST_K2LO: begin
				v3_q  <= prod_v2v[V2W+RAD_W-1:FRAC_BITS];
				plo_q <= mul_p[63:FRAC_BITS];
			end
			ST_K2HI: term2_q <= term;
			ST_K3LO: plo_q   <= mul_p[63:FRAC_BITS];
			ST_K3HI: term3_q <= term;
			ST_ACC: begin
				if (last_q && !acc_block) begin
					out_d_q <= dsum_n;
					out_n_q <= nsum_n;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign density      = out_d_q;
	assign near_density = out_n_q;

	`SDA_ASSERT_NOW(a_sqrt_bit, state_q == ST_SQRT, bit_q != '0, "sqrt ran past its last digit")
	`SDA_ASSERT_NEXT(a_pop_leaves_idle, pop, state_q != ST_IDLE, "popped item not taken up")
	`SDA_ASSERT_NOW(a_result_from_acc, $rose(out_valid_q), $past(state_q == ST_ACC) && $past(last_q), "result without a last accumulate")
	`SDA_ASSERT_NOW(a_no_overwrite, out_valid_q && !out_ready && state_q == ST_ACC && last_q, !pop, "result overwritten while stalled")
endmodule

// ----- test/sph_density_accumulator_top_tb.sv -----
`timescale 1ns / 1ps
module sph_density_accumulator_top_tb;
	import sda_pkg::*;

	localparam int          FRAC      = FRAC_BITS_DEF;
	localparam int          IDLE_LIM  = 20000;
	localparam int          SETTLE    = 100;
	localparam logic [1:0]  REG_SPARE = 2'd3;   // unmapped word address
	localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [SUM_W-1:0] near;
		logic [SUM_W-1:0] dens;
	} sums_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [71:0]         s_tdata;   // dx, dy, dz
	logic                s_tlast;   // last_neighbor
	logic                m_tvalid;
	logic                m_tready;
	logic [63:0]         m_tdata;   // density, near_density
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// predictor state
	logic [RAD_W-1:0]    radius_q;
	logic [COEFF_W-1:0]  k_dens;
	logic [COEFF_W-1:0]  k_near;
	logic [SUM_W-1:0]    acc_dens;
	logic [SUM_W-1:0]    acc_near;
	sums_t               pending_sums[$];

	int                  errors;
	int                  items_sent;
	int                  particles_done;
	int                  gap_max;
	int                  stall_max;
	int                  stall_cnt;
	int                  idle_cnt;
	bit                  long_hold_req;

	sph_density_accumulator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// floor square root, argument below 2^48
	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] trial;
		root = 0;
		for (int b = 24; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x) root = trial;
		end
		return root;
	endfunction

	// floor(a*b / 2^F), saturated to 32 bits
	function automatic logic [31:0] scale_sat(logic [63:0] a, logic [31:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {96'd0, b}) >> FRAC;
		return (p > {96'd0, SAT32}) ? SAT32 : p[31:0];
	endfunction

	function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? SAT32 : s[31:0];
	endfunction

	function automatic logic [63:0] magnitude(logic [COORD_W-1:0] c);
		return c[COORD_W-1] ? (64'd1 << COORD_W) - {40'd0, c} : {40'd0, c};
	endfunction

	// kernel accumulate for one accepted neighbour
	task automatic accumulate_neighbour(logic [23:0] dx, logic [23:0] dy, logic [23:0] dz,
			logic last);
		logic [63:0] sq, h, d, v, v2, v3;
		sums_t       r;
		sq = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)
			+ magnitude(dz) * magnitude(dz);
		h  = {41'd0, radius_q};
		if (sq <= h * h) begin
			d  = floor_sqrt(sq);
			v  = (d <= h) ? h - d : 0;
			v2 = (v * v) >> FRAC;
			v3 = (v2 * v) >> FRAC;
			acc_dens = add_sat32(acc_dens, scale_sat(v2, k_dens));
			acc_near = add_sat32(acc_near, scale_sat(v3, k_near));
		end
		if (last) begin
			r.dens = acc_dens;
			r.near = acc_near;
			pending_sums.push_back(r);
			acc_dens = 0;
			acc_near = 0;
		end
	endtask

	// one input transaction, predicted on acceptance
	task automatic send_neighbour(logic [23:0] dx, logic [23:0] dy, logic [23:0] dz,
			logic last);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {dz, dy, dx};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		accumulate_neighbour(dx, dy, dz, last);
		items_sent++;
	endtask

	// drop valid on the accepting edge so the last item is not offered again
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write, block idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RADIUS: radius_q = val[RAD_W-1:0];
			REG_DCOEFF: k_dens   = val;
			REG_NCOEFF: k_near   = val;
			default: ;
		endcase
	endtask

	task automatic set_kernel(logic [31:0] h, logic [31:0] kd, logic [31:0] kn);
		write_reg(REG_RADIUS, h);
		write_reg(REG_DCOEFF, kd);
		write_reg(REG_NCOEFF, kn);
	endtask

	// coordinate mostly inside the radius, sometimes anywhere
	function automatic logic [23:0] rand_coord();
		logic [23:0] c;
		if ($urandom_range(0, 4) == 0) return 24'($urandom);
		c = 24'($urandom_range(0, radius_q));
		if ($urandom_range(0, 3) != 0) c = c >> 1;
		return $urandom_range(0, 1) ? -c : c;
	endfunction

	// a particle: itself first, then neighbours, flagged last at the end
	task automatic send_particle(int n);
		send_neighbour(0, 0, 0, n == 1);
		for (int i = 1; i < n; i++)
			send_neighbour(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
	endtask

	task automatic test_directed();
		send_neighbour(0, 0, 0, 1'b1);
		send_neighbour(24'd65536, 0, 0, 1'b1);           // exactly on the radius
		send_neighbour(0, 24'd65537, 0, 1'b1);           // just outside
		send_neighbour(0, 0, -24'sd65536, 1'b1);
		send_neighbour(24'h800000, 24'h800000, 24'h800000, 1'b1);
		send_neighbour(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		send_neighbour(24'hFFFFFF, 24'd1, 24'hFFFFFF, 1'b0);
		send_neighbour(24'd30000, -24'sd20000, 24'd10000, 1'b0);
		send_neighbour(24'd0, 24'd0, 24'd0, 1'b1);
		send_neighbour(24'd40000, 24'd40000, 24'd40000, 1'b1);  // diagonal, out
		wait_drained();
		// write to the unmapped address must change nothing
		write_reg(REG_SPARE, 32'h1234_5678);
		send_neighbour(24'd100, 24'd200, 24'd300, 1'b1);
		wait_drained();
		// largest radius and coefficients: saturation
		set_kernel(32'h007F_FFFF, SAT32, SAT32);
		send_neighbour(0, 0, 0, 1'b0);
		send_neighbour(24'h7FFFFF, 0, 0, 1'b0);
		send_neighbour(24'h400000, 24'h400000, 24'hC00000, 1'b1);
		wait_drained();
		// zero radius: only the particle itself counts, adding nothing
		set_kernel(32'd0, 32'd156457, 32'd312914);
		send_neighbour(0, 0, 0, 1'b0);
		send_neighbour(24'd1, 0, 0, 1'b1);
		wait_drained();
		// smallest nonzero radius, zero coefficients
		set_kernel(32'd1, 32'd0, 32'd0);
		send_neighbour(0, 0, 0, 1'b0);
		send_neighbour(0, 24'd1, 0, 1'b1);
		wait_drained();
	endtask

	task automatic test_random(int n_items, logic [31:0] h, logic [31:0] kd, logic [31:0] kn);
		int start;
		set_kernel(h, kd, kn);
		start = items_sent;
		while (items_sent - start < n_items) begin
			send_particle($urandom_range(1, 12));
			if ($urandom_range(0, 30) == 0) begin
				// sender pauses until the block has drained
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_sums.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0) begin
				gap_max   = $urandom_range(0, 1) ? 16 : 0;
				stall_max = $urandom_range(0, 1) ? 16 : 0;
			end
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		gap_max   = 0;
		long_hold_req = 1'b1;
		for (int i = 0; i < 10; i++) send_particle(4);
		gap_max   = 16;
		stall_max = 16;
		wait_drained();
	endtask

	// result checker and receiver stall generator
	always @(posedge clk) begin
		sums_t exp_s;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$display("%t unexpected result density=%h near=%h", $time,
					m_tdata[31:0], m_tdata[63:32]);
				errors++;
			end else begin
				exp_s = pending_sums.pop_front();
				particles_done++;
				if (m_tdata[31:0] !== exp_s.dens) begin
					$display("%t density mismatch: expected %h actual %h", $time,
						exp_s.dens, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== exp_s.near) begin
					$display("%t near density mismatch: expected %h actual %h", $time,
						exp_s.near, m_tdata[63:32]);
					errors++;
				end
			end
			stall_cnt = $urandom_range(0, stall_max);
		end
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_cnt = 400;
		end
		if (stall_cnt != 0) begin
			stall_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIM) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk = 0; arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		errors = 0; items_sent = 0; particles_done = 0; idle_cnt = 0;
		gap_max = 16; stall_max = 16; stall_cnt = 0; long_hold_req = 0;
		radius_q = RADIUS_RST; k_dens = DENSITY_RST; k_near = NEAR_RST;
		acc_dens = 0; acc_near = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(400, 32'd65536, 32'd156457, 32'd312914);
		test_random(300, 32'd200000, 32'h0001_0000, 32'h0002_0000);
		test_random(150, 32'h007F_FFFF, SAT32, SAT32);
		test_random(150, 32'd1024, 32'hFFFF_0000, 32'h8000_0000);
		test_backpressure();
		test_random(250, 32'h0012_3457, 32'h0000_1234, 32'h0000_0000);

		$display("Covered %0d neighbour transactions and %0d particle sums over", items_sent,
			particles_done);
		$display("several radius and coefficient settings, including saturation and stalls.");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
